// ===== src/hcb_pkg.sv =====
`timescale 1ns / 1ps

package hcb_pkg;

  // One raw byte of the chunked body, with its end marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } hcb_in_t;

  // One result item: a payload byte and/or the end-of-body report.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic        end_of_body;
    logic [1:0]  end_status;
    logic [31:0] decoded_count;
  } hcb_out_t;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_LINE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_GAP     = 3'd4,
    PH_DONE    = 3'd5
  } hcb_phase_t;

  // End status codes.
  localparam logic [1:0] ST_TERMINATED = 2'd0;
  localparam logic [1:0] ST_OPEN       = 2'd1;
  localparam logic [1:0] ST_TRUNCATED  = 2'd2;

  // Character codes used by the size line parser.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Number of gap bytes after each chunk's payload.
  localparam logic [1:0] GAP_BYTES = 2'd2;

  // Returns {is_hex, value} for one byte.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== src/hcb_step.sv =====
`timescale 1ns / 1ps

module hcb_step #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_fire,
  input  hcb_pkg::hcb_in_t item,
  output logic             res_valid,
  output hcb_pkg::hcb_out_t res
);

  localparam int CW = COUNT_WIDTH;

  hcb_pkg::hcb_phase_t phase_r, phase_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          cr_r, cr_nxt;
  logic [1:0]    trail_r, trail_nxt;
  logic [31:0]   total_r, total_nxt;

  logic [4:0]    hex;
  logic [CW-1:0] acc_shift;
  logic [CW-1:0] rem_dec;
  logic [1:0]    trail_dec;
  logic          pay;

  // State registers; reset puts the decoder at the start of a size line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcb_pkg::PH_LEAD;
      acc_r   <= '0;
      rem_r   <= '0;
      cr_r    <= 1'b0;
      trail_r <= 2'd0;
      total_r <= 32'd0;
    end else if (item_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      cr_r    <= cr_nxt;
      trail_r <= trail_nxt;
      total_r <= total_nxt;
    end
  end

  // Datapath helpers. The size saturates once any of its top four bits is set.
  assign hex       = hcb_pkg::hex_digit(item.in_byte);
  assign acc_shift = (|acc_r[CW-1:CW-4]) ? {CW{1'b1}} : {acc_r[CW-5:0], hex[3:0]};
  assign rem_dec   = (rem_r == '0) ? '0 : rem_r - CW'(1);
  assign trail_dec = (trail_r == 2'd0) ? 2'd0 : trail_r - 2'd1;

  // Next state and result for one item.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    cr_nxt    = cr_r;
    trail_nxt = trail_r;
    total_nxt = total_r;
    pay       = 1'b0;

    case (phase_r)
      hcb_pkg::PH_LEAD, hcb_pkg::PH_DIGITS: begin
        if (phase_r == hcb_pkg::PH_LEAD &&
            (item.in_byte == hcb_pkg::CH_SPACE || item.in_byte == hcb_pkg::CH_TAB)) begin
          phase_nxt = phase_r;
        end else if (hex[4]) begin
          acc_nxt   = acc_shift;
          phase_nxt = hcb_pkg::PH_DIGITS;
        end else begin
          // The number ends here; the rest of the line is skipped up to CR LF.
          cr_nxt    = (item.in_byte == hcb_pkg::CH_CR);
          phase_nxt = hcb_pkg::PH_LINE;
        end
      end
      hcb_pkg::PH_LINE: begin
        if (cr_r && item.in_byte == hcb_pkg::CH_LF) begin
          cr_nxt    = 1'b0;
          acc_nxt   = '0;
          rem_nxt   = acc_r;
          phase_nxt = (acc_r == '0) ? hcb_pkg::PH_DONE : hcb_pkg::PH_PAYLOAD;
        end else begin
          cr_nxt = (item.in_byte == hcb_pkg::CH_CR);
        end
      end
      hcb_pkg::PH_PAYLOAD: begin
        pay       = 1'b1;
        total_nxt = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;
        rem_nxt   = rem_dec;
        if (rem_dec == '0) begin
          trail_nxt = hcb_pkg::GAP_BYTES;
          phase_nxt = hcb_pkg::PH_GAP;
        end
      end
      hcb_pkg::PH_GAP: begin
        trail_nxt = trail_dec;
        if (trail_dec == 2'd0) begin
          acc_nxt   = '0;
          phase_nxt = hcb_pkg::PH_LEAD;
        end
      end
      default: begin
        phase_nxt = hcb_pkg::PH_DONE;
      end
    endcase

    // Result fields.
    res_valid         = pay || item.in_last;
    res.out_byte      = pay ? item.in_byte : 8'd0;
    res.payload_valid = pay;
    res.end_of_body   = item.in_last;
    res.end_status    = hcb_pkg::ST_TERMINATED;
    res.decoded_count = 32'd0;
    if (item.in_last) begin
      if (phase_nxt == hcb_pkg::PH_DONE) begin
        res.end_status = hcb_pkg::ST_TERMINATED;
      end else if (phase_nxt == hcb_pkg::PH_PAYLOAD) begin
        res.end_status = hcb_pkg::ST_TRUNCATED;
      end else begin
        res.end_status = hcb_pkg::ST_OPEN;
      end
      res.decoded_count = total_nxt;

      // The last byte closes the body; the next byte starts a fresh one.
      phase_nxt = hcb_pkg::PH_LEAD;
      acc_nxt   = '0;
      rem_nxt   = '0;
      cr_nxt    = 1'b0;
      trail_nxt = 2'd0;
      total_nxt = 32'd0;
    end
  end

endmodule

// ===== src/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Type                 Handshake
// in_      input      hcb_pkg::hcb_in_t    in_valid / in_stall
// out_     output     hcb_pkg::hcb_out_t   out_valid / out_stall
//
// One byte per cycle sustained while the output is not stalled; a byte's result passes
// through the input register, then the decode step into the result register.
// The decoder state updates in the same cycle a byte leaves the input register through the decode step.
// Reset is synchronous and active low.
// While the result register is stalled, the input register still takes one more item.
// Bytes that produce no result free the pipeline at once.

module http_chunked_body_decoder #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcb_pkg::hcb_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hcb_pkg::hcb_out_t  out_data
);

  logic              s1_valid_r;
  hcb_pkg::hcb_in_t  s1_item_r;
  logic              out_valid_r;
  hcb_pkg::hcb_out_t out_data_r;

  logic              advance;
  logic              step_fire;
  logic              res_valid;
  hcb_pkg::hcb_out_t res;

  // The pipeline moves when the result register is empty or being taken.
  assign advance   = !out_valid_r || !out_stall;
  assign step_fire = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Decode step and state.
  hcb_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_fire(step_fire),
    .item     (s1_item_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Every result carries a payload byte or closes the body.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.payload_valid || out_data.end_of_body))
    else $error("result item with neither payload nor end of body");

  // Status and count are zero except on the end-of-body result.
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.end_of_body) |->
      (out_data.end_status == hcb_pkg::ST_TERMINATED && out_data.decoded_count == 32'd0))
    else $error("end fields set on a result that is not the end of body");

  // Input stalls only when both registers are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  // The end status is always one of the defined codes.
  a_no_status_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.end_status <= hcb_pkg::ST_TRUNCATED))
    else $error("undefined end status code");
`endif

endmodule

// ===== dv/hcb_decode_check.sv =====
`timescale 1ns / 1ps

// Watches both channels of the chunked body decoder, predicts the result items from the
// accepted input items and compares them in order.
module hcb_decode_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  hcb_pkg::hcb_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  hcb_pkg::hcb_out_t out_data,
  output int                fault_count,
  output int                results_owed,
  output int                payload_bytes,
  output int                ends_clean,
  output int                ends_open,
  output int                ends_truncated
);
  import hcb_pkg::*;

  // Predicted decoder state.
  hcb_phase_t  dec_phase;
  logic [31:0] size_acc;
  logic [31:0] chunk_left;
  logic        cr_pending;
  logic [1:0]  gap_left;
  logic [31:0] emitted_total;

  // Predicted result items, oldest first.
  hcb_out_t owed[$];

  initial begin
    fault_count    = 0;
    results_owed   = 0;
    payload_bytes  = 0;
    ends_clean     = 0;
    ends_open      = 0;
    ends_truncated = 0;
  end

  // Value of a hex digit, or -1 for any other byte.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  task automatic clear_decoder();
    dec_phase     = PH_LEAD;
    size_acc      = '0;
    chunk_left    = '0;
    cr_pending    = 1'b0;
    gap_left      = '0;
    emitted_total = '0;
  endtask

  // The tail of a size line ends only at CR followed by LF.
  task automatic line_tail(input logic [7:0] c);
    if (cr_pending && c == CH_LF) begin
      cr_pending = 1'b0;
      if (size_acc == 0) begin
        dec_phase = PH_DONE;
      end else begin
        chunk_left = size_acc;
        dec_phase  = PH_PAYLOAD;
      end
      size_acc = '0;
    end else begin
      cr_pending = (c == CH_CR);
      dec_phase  = PH_LINE;
    end
  endtask

  // Advances the predicted state by one byte and queues the result it causes, if any.
  task automatic decode_item(input hcb_in_t item);
    hcb_out_t    res;
    logic        fires;
    int          digit;
    logic [35:0] grown;
    fires = 1'b0;
    res   = '0;
    case (dec_phase)
      PH_LEAD, PH_DIGITS: begin
        digit = hex_val(item.in_byte);
        if (dec_phase == PH_LEAD && (item.in_byte == CH_SPACE || item.in_byte == CH_TAB)) begin
          // Blanks before the number are skipped.
        end else if (digit >= 0) begin
          // The size saturates instead of wrapping.
          grown = {4'd0, size_acc} * 36'd16 + 36'(digit);
          size_acc  = (grown > 36'hFFFFFFFF) ? '1 : grown[31:0];
          dec_phase = PH_DIGITS;
        end else begin
          cr_pending = 1'b0;
          line_tail(item.in_byte);
        end
      end
      PH_LINE: line_tail(item.in_byte);
      PH_PAYLOAD: begin
        fires             = 1'b1;
        res.out_byte      = item.in_byte;
        res.payload_valid = 1'b1;
        if (emitted_total != '1) emitted_total++;
        if (chunk_left != 0) chunk_left--;
        if (chunk_left == 0) begin
          gap_left  = GAP_BYTES;
          dec_phase = PH_GAP;
        end
      end
      PH_GAP: begin
        if (gap_left != 0) gap_left--;
        if (gap_left == 0) begin
          size_acc  = '0;
          dec_phase = PH_LEAD;
        end
      end
      default: dec_phase = PH_DONE;
    endcase

    // The last byte reports where decoding stood and starts a fresh body.
    if (item.in_last) begin
      fires           = 1'b1;
      res.end_of_body = 1'b1;
      if (dec_phase == PH_DONE) res.end_status = ST_TERMINATED;
      else if (dec_phase == PH_PAYLOAD) res.end_status = ST_TRUNCATED;
      else res.end_status = ST_OPEN;
      res.decoded_count = emitted_total;
      clear_decoder();
    end
    if (fires) owed.push_back(res);
  endtask

  // Compares one delivered result item with the oldest prediction.
  task automatic check_result(input hcb_out_t got);
    hcb_out_t want;
    if (owed.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: result with nothing predicted: byte %h valid %b end %b status %0d count %0d",
                 $time, got.out_byte, got.payload_valid, got.end_of_body, got.end_status,
                 got.decoded_count);
      return;
    end
    want = owed.pop_front();
    if (got.out_byte !== want.out_byte || got.payload_valid !== want.payload_valid ||
        got.end_of_body !== want.end_of_body || got.end_status !== want.end_status ||
        got.decoded_count !== want.decoded_count) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("%0t: result differs", $time);
        $display("  expected byte %h valid %b end %b status %0d count %0d",
                 want.out_byte, want.payload_valid, want.end_of_body, want.end_status,
                 want.decoded_count);
        $display("  actual   byte %h valid %b end %b status %0d count %0d",
                 got.out_byte, got.payload_valid, got.end_of_body, got.end_status,
                 got.decoded_count);
      end
    end
    if (want.payload_valid) payload_bytes++;
    if (want.end_of_body) begin
      case (want.end_status)
        ST_TERMINATED: ends_clean++;
        ST_TRUNCATED:  ends_truncated++;
        default:       ends_open++;
      endcase
    end
  endtask

  // Results are checked before the prediction of this edge's item, which cannot be among them.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      owed.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) decode_item(in_data);
    end
    results_owed = owed.size();
  end

endmodule

// ===== dv/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
  import hcb_pkg::*;

  localparam int BODY_ITEMS  = 1650;
  localparam int HOLD_CYCLES = 64;
  localparam int LIMIT_NS    = 5_000_000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hcb_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hcb_out_t out_data;

  int fault_count;
  int results_owed;
  int payload_bytes;
  int ends_clean;
  int ends_open;
  int ends_truncated;

  // Stimulus controls.
  int send_idle_pct;
  int stall_pct;
  int hold_reqs;
  int items_sent;
  int bodies_sent;
  int junk_count;
  logic [7:0] body_bytes[$];

  http_chunked_body_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hcb_decode_check decode_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fault_count    (fault_count),
    .results_owed   (results_owed),
    .payload_bytes  (payload_bytes),
    .ends_clean     (ends_clean),
    .ends_open      (ends_open),
    .ends_truncated (ends_truncated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("tb_http_chunked_body_decoder: errors");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request.
  initial begin : receiver
    int hold_left;
    int hold_done;
    int pct;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      pct = stall_pct;
      if (hold_left == 0 && hold_reqs != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < pct);
      end
    end
  end

  // Offers one item and returns after it is taken; valid stays high for the next call.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data.in_byte = b;
    in_data.in_last = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_body();
    int i;
    for (i = 0; i < body_bytes.size(); i++) push_byte(body_bytes[i], i == body_bytes.size() - 1);
    items_sent += body_bytes.size() - junk_count;
    bodies_sent++;
  endtask

  // The sender stops until every predicted result has come out.
  task automatic drain_wait();
    in_valid = 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endtask

  // Hex digits of a size in mixed case, sometimes with leading zeros.
  task automatic add_hex(input logic [31:0] v);
    logic [7:0] digs[$];
    logic [3:0] nib;
    do begin
      nib = v[3:0];
      if (nib < 10) digs.push_front(8'h30 + 8'(nib));
      else digs.push_front(($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib - 10));
      v = v >> 4;
    end while (v != 0);
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) digs.push_front("0");
    foreach (digs[i]) body_bytes.push_back(digs[i]);
  endtask

  // A size line with optional blanks, extension text and stray line-end bytes.
  task automatic add_size_line(input logic [31:0] size);
    logic [7:0] c;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) body_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    add_hex(size);
    case ($urandom_range(5))
      0: begin
        body_bytes.push_back(";");
        repeat ($urandom_range(4, 1)) begin
          c = 8'($urandom);
          body_bytes.push_back(c == CH_CR ? 8'h7E : c);
        end
      end
      1: body_bytes.push_back(CH_SPACE);
      2: body_bytes.push_back(CH_LF);
      3: begin
        body_bytes.push_back(CH_CR);
        body_bytes.push_back("z");
      end
      default: ;
    endcase
    body_bytes.push_back(CH_CR);
    body_bytes.push_back(CH_LF);
  endtask

  // Builds one body: mostly well formed with random content, some broken or pure noise.
  task automatic build_body(input bit long_chunk);
    int shape;
    int n_chunks;
    int size;
    int cut;
    int i;
    body_bytes.delete();
    junk_count = 0;
    shape = long_chunk ? 0 : $urandom_range(99);

    // Noise with no chunk structure at all.
    if (shape >= 92) begin
      repeat ($urandom_range(12, 1)) body_bytes.push_back(8'($urandom));
      return;
    end

    n_chunks = long_chunk ? 1 : $urandom_range(3);
    for (i = 0; i < n_chunks; i++) begin
      if (long_chunk) size = 40;
      else if ($urandom_range(9) == 0) size = $urandom_range(48, 7);
      else size = $urandom_range(6, 1);
      add_size_line(size);
      repeat (size) body_bytes.push_back(8'($urandom));
      if ($urandom_range(4) == 0) begin
        body_bytes.push_back(8'($urandom));
        body_bytes.push_back(8'($urandom));
      end else begin
        body_bytes.push_back(CH_CR);
        body_bytes.push_back(CH_LF);
      end
    end

    if (shape >= 86) begin
      // A sign or a 0x prefix leaves the size at zero, so this line terminates.
      case ($urandom_range(2))
        0: body_bytes.push_back("+");
        1: body_bytes.push_back("-");
        default: add_text("0x");
      endcase
      add_hex($urandom_range(255, 1));
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
    end else if (shape >= 80) begin
      // An oversized chunk that saturates, cut off after a few payload bytes.
      body_bytes.push_back("1");
      add_hex('1);
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
      repeat ($urandom_range(4, 1)) body_bytes.push_back(8'($urandom));
      return;
    end else begin
      add_size_line(0);
    end

    // Trailing bytes after the terminator are ignored by the block.
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(2, 1)) begin
        body_bytes.push_back(8'($urandom));
        junk_count++;
      end

    // Some bodies end early, inside a line, a payload or a gap.
    if (!long_chunk && shape >= 65 && shape < 80) begin
      cut = $urandom_range(body_bytes.size() - 1, 1);
      while (body_bytes.size() > cut) body_bytes.pop_back();
      junk_count = 0;
    end
  endtask

  initial begin : stimulus
    int ph;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    items_sent    = 0;
    bodies_sent   = 0;
    junk_count    = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Leading tab, payload byte extremes and a clean terminator.
    body_bytes.delete();
    add_text("\t2\r\n");
    body_bytes.push_back(8'h00);
    body_bytes.push_back(8'hFF);
    add_text("\r\n0\r\n");
    send_body();

    // A size past the counter range saturates; the chunk then ends short.
    body_bytes.delete();
    add_text("1FFFFFFFF\r\na");
    send_body();

    // 0x gives size zero; a lone LF and a CR before CR do not end the line.
    body_bytes.delete();
    add_text("0x\n\r\r\nZ");
    send_body();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase

      // Back up the block with a long chunk while the result side holds off.
      if (ph == 0) begin
        hold_reqs++;
        build_body(1'b1);
        send_body();
        drain_wait();
      end

      while (items_sent < (ph + 1) * BODY_ITEMS / 4) begin
        build_body(1'b0);
        send_body();
      end
      drain_wait();
    end

    in_valid = 1'b0;
    wait (results_owed == 0);
    repeat (12) @(posedge clk);

    $display("Sent %0d bodies, %0d counted bytes; %0d payload bytes came back.",
             bodies_sent, items_sent, payload_bytes);
    $display("Body ends: %0d terminated, %0d inside a line or gap, %0d truncated.",
             ends_clean, ends_open, ends_truncated);
    if (fault_count == 0) begin
      $display("tb_http_chunked_body_decoder: clean");
    end else begin
      $display("tb_http_chunked_body_decoder: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/hcb_pkg.sv
src/hcb_step.sv
src/http_chunked_body_decoder.sv
dv/hcb_decode_check.sv
dv/tb_http_chunked_body_decoder.sv
